// ----- rtl/usd_pkg.sv -----
// Shared types, constants and helpers for the underscore escape decoder.
package usd_pkg;

  localparam logic [7:0] ESC_CHAR     = 8'h5F;
  localparam logic [7:0] LETTER_S     = 8'h73;
  localparam logic [7:0] LETTER_N     = 8'h6E;
  localparam logic [7:0] LETTER_X     = 8'h78;
  localparam logic [7:0] NEWLINE_BYTE = 8'h0A;

  // results one input item can cause, and the result queue depth
  localparam int MAX_RESULTS = 3;
  localparam int QUEUE_DEPTH = 4;

  typedef enum logic [1:0] {
    KIND_CHAR = 2'd0,
    KIND_END  = 2'd1,
    KIND_ERR  = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ERR_MISSING_CHAR = 2'd0,
    ERR_BAD_HEX      = 2'd1,
    ERR_MISSING_HEX  = 2'd2,
    ERR_NONE         = 2'd3
  } err_t;

  typedef enum logic [1:0] {
    MODE_PLAIN = 2'd0,
    MODE_ESC   = 2'd1,
    MODE_HEX1  = 2'd2,
    MODE_HEX2  = 2'd3
  } mode_t;

  typedef struct packed {
    mode_t      mode;
    logic [7:0] first_digit;
    logic       nonempty;
  } dec_state_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] data;
    logic [1:0] err_code;
    logic       last;
  } result_t;

  typedef struct packed {
    logic [1:0]                    count;
    result_t [MAX_RESULTS-1:0]     res;
  } res_bundle_t;

  // {valid, nibble} for an ASCII hex digit of either case
  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [4:0] v;
    v = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) v = {1'b1, 4'(c - 8'h30)};
    else if (c >= 8'h61 && c <= 8'h66) v = {1'b1, 4'(c - 8'h61 + 8'd10)};
    else if (c >= 8'h41 && c <= 8'h46) v = {1'b1, 4'(c - 8'h41 + 8'd10)};
    return v;
  endfunction

endpackage

// ----- rtl/usd_decode.sv -----
// Combinational decode of one byte: next parser state and up to three results.
module usd_decode (
  input  usd_pkg::dec_state_t  state,
  input  logic [7:0]           in_byte,
  input  logic                 is_final,
  output usd_pkg::dec_state_t  state_next,
  output usd_pkg::res_bundle_t bundle
);
  import usd_pkg::*;

  logic [4:0] d1;
  logic [4:0] d2;
  logic [1:0] n;
  result_t [MAX_RESULTS-1:0] res;
  dec_state_t st;

  assign d1 = hex_value(state.first_digit);
  assign d2 = hex_value(in_byte);

  always_comb begin
    n   = 2'd0;
    res = '0;
    st  = state;
    st.mode = MODE_PLAIN;
    unique case (state.mode)
      MODE_PLAIN: begin
        if (in_byte == ESC_CHAR) begin
          if (is_final) begin
            res[n] = '{kind: KIND_ERR, data: 8'd0, err_code: ERR_MISSING_CHAR, last: 1'b0};
            n = n + 2'd1;
          end else begin
            st.mode = MODE_ESC;
          end
        end else begin
          res[n] = '{kind: KIND_CHAR, data: in_byte, err_code: 2'd0, last: 1'b0};
          n = n + 2'd1;
          st.nonempty = 1'b1;
        end
      end
      MODE_ESC: begin
        if (in_byte == LETTER_S) begin
          if (state.nonempty) begin
            res[n] = '{kind: KIND_END, data: 8'd0, err_code: 2'd0, last: 1'b0};
            n = n + 2'd1;
          end
          st.nonempty = 1'b0;
        end else if (in_byte == LETTER_N) begin
          res[n] = '{kind: KIND_CHAR, data: NEWLINE_BYTE, err_code: 2'd0, last: 1'b0};
          n = n + 2'd1;
          st.nonempty = 1'b1;
        end else if (in_byte == LETTER_X) begin
          if (is_final) begin
            res[n] = '{kind: KIND_ERR, data: 8'd0, err_code: ERR_MISSING_HEX, last: 1'b0};
            n = n + 2'd1;
          end else begin
            st.mode = MODE_HEX1;
          end
        end
      end
      MODE_HEX1: begin
        if (is_final) begin
          res[n] = '{kind: KIND_ERR, data: 8'd0, err_code: ERR_MISSING_HEX, last: 1'b0};
          n = n + 2'd1;
          // leftover byte goes through as plain text
          if (in_byte == ESC_CHAR) begin
            res[n] = '{kind: KIND_ERR, data: 8'd0, err_code: ERR_MISSING_CHAR, last: 1'b0};
          end else begin
            res[n] = '{kind: KIND_CHAR, data: in_byte, err_code: 2'd0, last: 1'b0};
            st.nonempty = 1'b1;
          end
          n = n + 2'd1;
        end else begin
          st.first_digit = in_byte;
          st.mode = MODE_HEX2;
        end
      end
      MODE_HEX2: begin
        if (d1[4] && d2[4]) begin
          res[n] = '{kind: KIND_CHAR, data: {d1[3:0], d2[3:0]}, err_code: 2'd0, last: 1'b0};
          st.nonempty = 1'b1;
        end else begin
          res[n] = '{kind: KIND_ERR, data: 8'd0, err_code: ERR_BAD_HEX, last: 1'b0};
        end
        n = n + 2'd1;
      end
      default: ;
    endcase

    if (is_final) begin
      if (st.nonempty) begin
        res[n] = '{kind: KIND_END, data: 8'd0, err_code: 2'd0, last: 1'b0};
        n = n + 2'd1;
      end
      st = '{mode: MODE_PLAIN, first_digit: 8'd0, nonempty: 1'b0};
    end

    for (int i = 0; i < MAX_RESULTS; i++) begin
      res[i].last = (n != 2'd0) && (2'(i) == n - 2'd1);
    end
  end

  assign state_next   = st;
  assign bundle.count = n;
  assign bundle.res   = res;

endmodule

// ----- rtl/underscore_escape_decoder_top.sv -----
// Underscore escape decoder: stream in, decode, result queue, stream out.
// Each accepted byte's results are written to the result queue together; m_tvalid presents the queue head.
// Throughput: one byte per cycle while each byte yields at most one result and m_tready
//   stays high; a byte yielding several results is drained one result per cycle, while
//   m_tready is high, from a 4-entry queue.
// A new byte is taken whenever the queue holds at most one result.
// Reset (rst, synchronous): parser back to plain text, string empty, queue flushed.
module underscore_escape_decoder_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] in_byte
  input  logic        s_tlast,   // is_final
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [7:0] out_byte, [9:8] err_code, [15:10] zero
  output logic [1:0]  m_tuser,   // [1:0] out_kind
  output logic        m_tlast    // run_last
);
  import usd_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  dec_state_t  state;
  dec_state_t  state_next;
  res_bundle_t bundle;

  result_t            queue [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;
  logic               in_fire;
  logic               out_fire;
  result_t            head;

  usd_decode u_decode (
    .state      (state),
    .in_byte    (s_tdata),
    .is_final   (s_tlast),
    .state_next (state_next),
    .bundle     (bundle)
  );

  assign s_tready = (count <= CNT_W'(1));
  assign in_fire  = s_tvalid && s_tready;
  assign m_tvalid = (count != '0);
  assign out_fire = m_tvalid && m_tready;

  assign head    = queue[rd_ptr];
  assign m_tdata = {6'd0, head.err_code, head.data};
  assign m_tuser = head.kind;
  assign m_tlast = head.last;

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= '{mode: MODE_PLAIN, first_digit: 8'd0, nonempty: 1'b0};
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (in_fire) begin
        state  <= state_next;
        wr_ptr <= wr_ptr + PTR_W'(bundle.count);
      end
      if (out_fire) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      count <= count + (in_fire ? CNT_W'(bundle.count) : CNT_W'(0))
                     - (out_fire ? CNT_W'(1) : CNT_W'(0));
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      for (int i = 0; i < MAX_RESULTS; i++) begin
        if (2'(i) < bundle.count) begin
          queue[wr_ptr + PTR_W'(i)] <= bundle.res[i];
        end
      end
    end
  end

`ifndef SYNTHESIS
  // queue never overfills
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(QUEUE_DEPTH))
    else $error("result queue overflow");

  // a result not closing its item always has its successor already queued
  a_run_complete: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tlast) |-> (count >= CNT_W'(2)))
    else $error("partial result run in queue");

  // the final byte of an input leaves the parser in plain text with an empty string
  a_final_resets: assert property (@(posedge clk) disable iff (rst)
    (in_fire && s_tlast) |=> (state.mode == MODE_PLAIN && !state.nonempty))
    else $error("parser not reset after final byte");

  a_reset_flush: assert property (@(posedge clk)
    rst |=> (count == '0))
    else $error("queue not flushed by reset");
`endif

endmodule

// ----- tb/tb_top.sv -----
// Testbench for the underscore escape decoder: directed table, random byte streams, result checks.
`timescale 1ns / 100ps

module tb_top;
  import usd_pkg::*;

  localparam logic [1:0] NO_ERR = 2'd0;   // err_code carried by chars and string ends
  localparam int PREDICT = -1;            // row takes its expectations from the decoder model
  localparam int N_RANDOM = 400;
  localparam int DRAIN_CYCLES = 3;
  localparam int TAIL_CYCLES = 10;
  localparam int STALL_LIMIT = 2000;

  typedef struct {
    logic [7:0]    b;
    logic          fin;
    int            ntyped;
    result_t [2:0] typed;
  } byte_item_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'h00;
  logic        s_tlast = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;
  logic [1:0]  m_tuser;
  logic        m_tlast;

  byte_item_t byte_items[$];
  result_t    pending_results[$];
  result_t    step_res[$];
  int         n_directed;
  int         n_taken = 0;
  int         n_results = 0;
  int         n_errors = 0;
  int         phase = 0;
  int         stall_cnt = 0;

  // decoder model state
  mode_t      dec_mode = MODE_PLAIN;
  logic [7:0] dec_digit = 8'h00;
  logic       dec_open = 1'b0;

  underscore_escape_decoder_top u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic result_t chr(logic [7:0] d, logic last);
    result_t r;
    r.kind = KIND_CHAR;
    r.data = d;
    r.err_code = NO_ERR;
    r.last = last;
    return r;
  endfunction

  function automatic result_t sig(kind_t k, logic [1:0] code, logic last);
    result_t r;
    r.kind = k;
    r.data = 8'h00;
    r.err_code = code;
    r.last = last;
    return r;
  endfunction

  function automatic void add_row(logic [7:0] b, logic fin, int ntyped,
                                  result_t r0 = '0, result_t r1 = '0, result_t r2 = '0);
    byte_item_t row;
    row.b = b;
    row.fin = fin;
    row.ntyped = ntyped;
    row.typed[0] = r0;
    row.typed[1] = r1;
    row.typed[2] = r2;
    byte_items.insert(byte_items.size(), row);
  endfunction

  // {valid, value} of an ASCII hex digit
  function automatic logic [4:0] hex_nibble(logic [7:0] c);
    logic [7:0] folded;
    folded = c | 8'h20;   // upper-case letters fold onto lower case
    if (c >= 8'h30 && c <= 8'h39) return {1'b1, c[3:0]};
    if (folded >= 8'h61 && folded <= 8'h66) return {1'b1, folded[3:0] + 4'd9};
    return 5'd0;
  endfunction

  function automatic void emit(kind_t k, logic [7:0] d, logic [1:0] code);
    result_t r;
    r.kind = k;
    r.data = d;
    r.err_code = code;
    r.last = 1'b0;
    step_res.insert(step_res.size(), r);
    if (k == KIND_CHAR) dec_open = 1'b1;
  endfunction

  function automatic mode_t plain_text(logic [7:0] b, logic fin);
    if (b != ESC_CHAR) begin
      emit(KIND_CHAR, b, NO_ERR);
      return MODE_PLAIN;
    end
    if (fin) begin
      emit(KIND_ERR, 8'h00, ERR_MISSING_CHAR);
      return MODE_PLAIN;
    end
    return MODE_ESC;
  endfunction

  // results of one accepted byte, left in step_res
  function automatic void decode_byte(logic [7:0] b, logic fin);
    mode_t      nxt;
    logic [4:0] hi;
    logic [4:0] lo;
    step_res.delete();
    nxt = MODE_PLAIN;
    hi = hex_nibble(dec_digit);
    lo = hex_nibble(b);
    case (dec_mode)
      MODE_PLAIN: nxt = plain_text(b, fin);
      MODE_ESC: begin
        if (b == LETTER_S) begin
          if (dec_open) emit(KIND_END, 8'h00, NO_ERR);
          dec_open = 1'b0;
        end else if (b == LETTER_N) begin
          emit(KIND_CHAR, NEWLINE_BYTE, NO_ERR);
        end else if (b == LETTER_X) begin
          if (fin) emit(KIND_ERR, 8'h00, ERR_MISSING_HEX);
          else nxt = MODE_HEX1;
        end
      end
      MODE_HEX1: begin
        if (fin) begin
          emit(KIND_ERR, 8'h00, ERR_MISSING_HEX);
          void'(plain_text(b, 1'b1));
        end else begin
          dec_digit = b;
          nxt = MODE_HEX2;
        end
      end
      default: begin
        if (hi[4] && lo[4]) emit(KIND_CHAR, {hi[3:0], lo[3:0]}, NO_ERR);
        else emit(KIND_ERR, 8'h00, ERR_BAD_HEX);
      end
    endcase
    dec_mode = nxt;
    if (fin) begin
      if (dec_open) emit(KIND_END, 8'h00, NO_ERR);
      dec_mode = MODE_PLAIN;
      dec_digit = 8'h00;
      dec_open = 1'b0;
    end
    if (step_res.size() != 0) step_res[step_res.size() - 1].last = 1'b1;
  endfunction

  function automatic void build_directed();
    add_row(8'h41, 1'b0, 1, chr(8'h41, 1'b1));
    add_row(8'h00, 1'b0, 1, chr(8'h00, 1'b1));
    add_row(ESC_CHAR, 1'b0, 0);
    add_row(LETTER_S, 1'b0, 1, sig(KIND_END, NO_ERR, 1'b1));
    // close of an empty string is silent
    add_row(ESC_CHAR, 1'b0, 0);
    add_row(LETTER_S, 1'b0, 0);
    add_row(ESC_CHAR, 1'b0, 0);
    add_row(LETTER_N, 1'b0, 1, chr(NEWLINE_BYTE, 1'b1));
    add_row(ESC_CHAR, 1'b0, PREDICT);
    add_row(LETTER_X, 1'b0, PREDICT);
    add_row("a", 1'b0, PREDICT);
    add_row("F", 1'b0, PREDICT);
    add_row(ESC_CHAR, 1'b0, 0);
    add_row(LETTER_X, 1'b0, 0);
    add_row("G", 1'b0, 0);
    add_row("0", 1'b0, 1, sig(KIND_ERR, ERR_BAD_HEX, 1'b1));
    add_row(ESC_CHAR, 1'b0, 0);
    add_row("q", 1'b0, 0);
    add_row(ESC_CHAR, 1'b1, 2, sig(KIND_ERR, ERR_MISSING_CHAR, 1'b0),
            sig(KIND_END, NO_ERR, 1'b1));
    add_row(ESC_CHAR, 1'b0, 0);
    add_row(LETTER_X, 1'b1, 1, sig(KIND_ERR, ERR_MISSING_HEX, 1'b1));
    add_row(ESC_CHAR, 1'b0, 0);
    add_row(LETTER_X, 1'b0, 0);
    add_row(ESC_CHAR, 1'b1, 2, sig(KIND_ERR, ERR_MISSING_HEX, 1'b0),
            sig(KIND_ERR, ERR_MISSING_CHAR, 1'b1));
    add_row(8'hFF, 1'b1, 2, chr(8'hFF, 1'b0), sig(KIND_END, NO_ERR, 1'b1));
  endfunction

  function automatic logic [7:0] rand_hex_digit();
    int k;
    k = $urandom_range(0, 21);
    if (k < 10) return 8'h30 + 8'(k);
    if (k < 16) return 8'h61 + 8'(k - 10);
    return 8'h41 + 8'(k - 16);
  endfunction

  function automatic void build_random(int target);
    int k;
    while (byte_items.size() < target) begin
      k = $urandom_range(0, 99);
      if (k < 30) begin
        add_row(8'($urandom_range(0, 255)), 1'b0, PREDICT);
      end else if (k < 40) begin
        add_row(ESC_CHAR, 1'b0, PREDICT);
        add_row(LETTER_S, 1'b0, PREDICT);
      end else if (k < 50) begin
        add_row(ESC_CHAR, 1'b0, PREDICT);
        add_row(LETTER_N, 1'b0, PREDICT);
      end else if (k < 68) begin
        add_row(ESC_CHAR, 1'b0, PREDICT);
        add_row(LETTER_X, 1'b0, PREDICT);
        add_row(rand_hex_digit(), 1'b0, PREDICT);
        add_row(rand_hex_digit(), 1'b0, PREDICT);
      end else if (k < 75) begin
        add_row(ESC_CHAR, 1'b0, PREDICT);
        add_row(LETTER_X, 1'b0, PREDICT);
        add_row(8'($urandom_range(0, 255)), 1'b0, PREDICT);
        add_row(8'($urandom_range(0, 255)), 1'b0, PREDICT);
      end else if (k < 82) begin
        add_row(ESC_CHAR, 1'b0, PREDICT);
        add_row(8'($urandom_range(0, 255)), 1'b0, PREDICT);
      end else if (k < 90) begin
        // escape cut short by the end of input
        add_row(ESC_CHAR, 1'b0, PREDICT);
        if (k >= 85) add_row(LETTER_X, 1'b0, PREDICT);
        if (k >= 88) add_row(8'($urandom_range(0, 255)), 1'b0, PREDICT);
      end else begin
        repeat ($urandom_range(1, 4)) add_row(8'($urandom_range(0, 255)), 1'b0, PREDICT);
      end
      if ((k >= 82 && k < 90) || $urandom_range(0, 7) == 0)
        byte_items[byte_items.size() - 1].fin = 1'b1;
    end
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    n_errors++;
    if (n_errors <= 40)
      $display("mismatch at result %0d: %s got 0x%0h, expected 0x%0h",
               n_results, what, got, want);
  endtask

  // input side: predict each accepted item
  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready) begin
      decode_byte(s_tdata, s_tlast);
      if (byte_items[n_taken].ntyped == PREDICT) begin
        foreach (step_res[k]) pending_results.insert(pending_results.size(), step_res[k]);
      end else begin
        for (int k = 0; k < byte_items[n_taken].ntyped; k++)
          pending_results.insert(pending_results.size(), byte_items[n_taken].typed[k]);
      end
      n_taken++;
    end
  end

  // output side: compare with the oldest expectation
  always @(posedge clk) begin
    result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with nothing expected, kind", m_tuser, 0);
      end else begin
        want = pending_results.pop_front();
        if (m_tuser != want.kind) report_mismatch("out_kind", m_tuser, want.kind);
        if (m_tdata[7:0] != want.data) report_mismatch("out_byte", m_tdata[7:0], want.data);
        if (m_tdata[9:8] != want.err_code)
          report_mismatch("err_code", m_tdata[9:8], want.err_code);
        if (m_tlast != want.last) report_mismatch("run_last", m_tlast, want.last);
      end
      n_results++;
    end
  end

  always @(posedge clk) begin
    case (phase)
      2: m_tready <= ($urandom_range(0, 99) >= 46);
      3: m_tready <= ($urandom_range(0, 99) >= 17);
      default: m_tready <= 1'b1;
    endcase
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      stall_cnt <= 0;
    end else begin
      stall_cnt <= stall_cnt + 1;
      if (stall_cnt >= STALL_LIMIT) begin
        $display("timeout: no item moved for %0d cycles", STALL_LIMIT);
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  initial begin : drive
    int gap_pct;
    int n_rand;
    build_directed();
    n_directed = byte_items.size();
    build_random(n_directed + N_RANDOM);
    n_rand = byte_items.size() - n_directed;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    for (int i = 0; i < byte_items.size(); i++) begin
      if (i == n_directed) begin
        // hold off until the decoder has drained
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
      end
      phase = (i < n_directed) ? 0 : (i - n_directed) * 4 / n_rand;
      gap_pct = (phase == 1) ? 46 : (phase == 3) ? 17 : 0;
      while ($urandom_range(0, 99) < gap_pct) begin
        s_tvalid <= 1'b0;
        @(posedge clk);
      end
      s_tvalid <= 1'b1;
      s_tdata <= byte_items[i].b;
      s_tlast <= byte_items[i].fin;
      @(posedge clk);
      while (!s_tready) @(posedge clk);
    end
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (n_errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ----- underscore_escape_decoder_top.f -----
rtl/usd_pkg.sv
rtl/usd_decode.sv
rtl/underscore_escape_decoder_top.sv
tb/tb_top.sv
